// ===== design/swm_pkg.sv =====
// shared types, sizes and helpers for the sliding-window median filter
// no dependencies; imported by every module of the block

package swm_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 32;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int CFG_BITS    = 6;

    // register map, word index = byte address / 4
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = CFG_BITS'(3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SAMPLE_BITS:0]   median_t;

    // what one cell shows its neighbours
    typedef struct packed {
        sample_t             value;
        logic [IDX_BITS-1:0] age;
        logic                valid;  // occupied and not being cleared
        logic                le;     // valid and value <= incoming sample
        logic                d_le;   // deleted entry at or below this cell
    } swm_link_t;

    // broadcast to every cell
    typedef struct packed {
        sample_t             sample;
        logic                clr;
        logic                full;
        logic [IDX_BITS-1:0] kminus1;
    } swm_ctl_t;

    // one-hot tap of the lower middle rank
    function automatic logic [WINDOW_MAX-1:0] tap_lo(input logic [CNT_BITS-1:0] k);
        logic [WINDOW_MAX-1:0] m;
        logic [CNT_BITS-1:0]   idx;
        m   = '0;
        idx = (k - CNT_BITS'(1)) >> 1;
        m[idx[IDX_BITS-1:0]] = 1'b1;
        return m;
    endfunction

    // one-hot tap of the upper middle rank
    function automatic logic [WINDOW_MAX-1:0] tap_hi(input logic [CNT_BITS-1:0] k);
        logic [WINDOW_MAX-1:0] m;
        logic [CNT_BITS-1:0]   idx;
        m   = '0;
        idx = k >> 1;
        m[idx[IDX_BITS-1:0]] = 1'b1;
        return m;
    endfunction

endpackage

// ===== design/sliding_window_median_top.sv =====
// top level of the sliding-window median filter: stream ports, apb register,
// chain of sorting cells and output register; depends on swm_pkg, swm_cell, swm_median
//
//  channel   direction  signals                          content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser sample, start_new
//  m_*       out        m_tvalid m_tready m_tdata         median_doubled
//  apb       in/out     psel penable pwrite paddr ...     window_size at 0x0
//
// one sample is taken every cycle while s_tready is high; its result reaches m_tdata
// through the cell update, then middle-rank select and add into the output register
// the cells keep the window sorted: each transfer drops the oldest entry once
// the window is full and inserts the new one, all cells deciding in parallel
// reset empties the window and sets window_size to 3; no clearing pass
// s_tready falls only when a result waits in the select stage and the output
// register is held by a stalled m_tready

module sliding_window_median_top
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic [0:0]  s_tuser,   // [0] start_new
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [32:0] median_doubled, [39:33] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration register
    logic [CFG_BITS-1:0] window_size_reg;
    logic                cfg_write;
    logic [CNT_BITS-1:0] k_eff;

    // window occupancy and pipeline control
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] n_eff;
    logic                full;
    logic                produce;
    logic                accept;
    logic                pend_reg, pend_next;
    logic                out_valid_reg;
    median_t             out_data_reg;
    logic                out_free;

    // middle rank taps
    logic [WINDOW_MAX-1:0] lo_sel_reg;
    logic [WINDOW_MAX-1:0] hi_sel_reg;

    swm_ctl_t  ctl;
    swm_link_t links     [WINDOW_MAX];
    swm_link_t below_w   [WINDOW_MAX];
    swm_link_t above_w   [WINDOW_MAX];
    sample_t   cell_vals [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] occ;
    median_t   median_sum;

    // apb: always ready, one register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW_SIZE);
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? {{(32-CFG_BITS){1'b0}}, window_size_reg}
                                                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            window_size_reg <= pwdata[CFG_BITS-1:0];
        end
    end

    // zero means one, anything above the chain length saturates
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = CNT_BITS'(1);
        end
        else if (window_size_reg > CFG_BITS'(WINDOW_MAX))
        begin
            k_eff = CNT_BITS'(WINDOW_MAX);
        end
        else
        begin
            k_eff = window_size_reg[CNT_BITS-1:0];
        end
    end

    // registered taps: the user must write window_size only while idle; not enforced
    always_ff @(posedge clk)
    begin
        lo_sel_reg <= tap_lo(k_eff);
        hi_sel_reg <= tap_hi(k_eff);
    end

    // handshake
    assign out_free = ~out_valid_reg | m_tready;
    assign s_tready = ~pend_reg | out_free;
    assign accept   = s_tvalid & s_tready;

    // fill tracking; start_new empties the window ahead of its own sample
    always_comb
    begin
        n_eff    = s_tuser[0] ? '0 : cnt_reg;
        full     = (n_eff == k_eff);
        produce  = full | ((n_eff + CNT_BITS'(1)) == k_eff);
        cnt_next = full ? cnt_reg : n_eff + CNT_BITS'(1);
    end

    always_comb
    begin
        if (accept)
        begin
            pend_next = produce;
        end
        else
        begin
            pend_next = pend_reg & ~out_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cnt_reg <= '0;
            end
            else if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            pend_reg <= pend_next;
            if (pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the cells still hold the window of the pending result in this cycle
    always_ff @(posedge clk)
    begin
        if (pend_reg && out_free)
        begin
            out_data_reg <= median_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40-SAMPLE_BITS-1){1'b0}}, out_data_reg};

    // broadcast to the chain
    always_comb
    begin
        ctl.sample  = s_tdata[SAMPLE_BITS-1:0];
        ctl.clr     = s_tuser[0];
        ctl.full    = full;
        ctl.kminus1 = IDX_BITS'(k_eff - CNT_BITS'(1));
    end

    // chain of cells, ascending from cell 0; the ends act as minus and
    // plus infinity
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        if (i == 0)
        begin : g_bottom
            assign below_w[i] = '{value: '0, age: '0, valid: 1'b1, le: 1'b1, d_le: 1'b0};
        end
        else
        begin : g_mid_below
            assign below_w[i] = links[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_top
            assign above_w[i] = '{value: '0, age: '0, valid: 1'b0, le: 1'b0, d_le: 1'b0};
        end
        else
        begin : g_mid_above
            assign above_w[i] = links[i+1];
        end

        swm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (accept),
            .flush    (cfg_write),
            .ctl      (ctl),
            .below    (below_w[i]),
            .above    (above_w[i]),
            .link     (links[i]),
            .occupied (occ[i]),
            .value    (cell_vals[i])
        );
    end

    swm_median u_median (
        .vals   (cell_vals),
        .lo_sel (lo_sel_reg),
        .hi_sel (hi_sel_reg),
        .sum    (median_sum)
    );

    // the occupied cells form a sorted run from the bottom
    logic [WINDOW_MAX-2:0] order_ok;
    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX - 1; i++)
        begin
            order_ok[i] = ~occ[i+1] | (occ[i] & (cell_vals[i] <= cell_vals[i+1]));
        end
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ) == 32'(cnt_reg))
        else $error("occupied cells disagree with fill count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= k_eff)
        else $error("fill count above window length");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("window cells out of order");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (pend_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

endmodule

// ===== design/swm_cell.sv =====
// one cell of the sorted window: value, age and occupancy
// depends on swm_pkg

module swm_cell
    import swm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      flush,
    input  swm_ctl_t  ctl,
    input  swm_link_t below,
    input  swm_link_t above,
    output swm_link_t link,
    output logic      occupied,
    output sample_t   value
);

    sample_t             value_reg, value_next;
    logic [IDX_BITS-1:0] age_reg, age_next;
    logic                valid_reg, valid_next;

    logic      own_valid;
    logic      del;
    swm_link_t r;   // this slot after removal of the oldest
    swm_link_t rb;  // slot below after removal

    always_comb
    begin
        own_valid = valid_reg & ~ctl.clr;
        del       = own_valid & ctl.full & (age_reg == ctl.kminus1);

        link.value = value_reg;
        link.age   = age_reg;
        link.valid = own_valid;
        link.le    = own_valid & (value_reg <= ctl.sample);
        link.d_le  = below.d_le | del;

        r  = link.d_le  ? above : link;
        rb = below.d_le ? link  : below;

        if (r.le)
        begin
            value_next = r.value;
            age_next   = r.age + IDX_BITS'(1);
            valid_next = r.valid;
        end
        else if (rb.le)
        begin
            value_next = ctl.sample;
            age_next   = '0;
            valid_next = 1'b1;
        end
        else
        begin
            value_next = rb.value;
            age_next   = rb.age + IDX_BITS'(1);
            valid_next = rb.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign occupied = valid_reg;
    assign value    = value_reg;

endmodule

// ===== design/swm_median.sv =====
// picks the two middle ranks from the sorted cells and adds them
// depends on swm_pkg

module swm_median
    import swm_pkg::*;
(
    input  sample_t                vals [WINDOW_MAX],
    input  logic [WINDOW_MAX-1:0]  lo_sel,
    input  logic [WINDOW_MAX-1:0]  hi_sel,
    output median_t                sum
);

    sample_t lo_val;
    sample_t hi_val;

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            lo_val = lo_val | (vals[i] & {SAMPLE_BITS{lo_sel[i]}});
            hi_val = hi_val | (vals[i] & {SAMPLE_BITS{hi_sel[i]}});
        end
        sum = median_t'(lo_val) + median_t'(hi_val);
    end

endmodule
